// ----- rtl/rtt_pkg.sv -----
// Shared types and constants for the range translation table.
`timescale 1ns / 1ps
`default_nettype none
package rtt_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 64;
   localparam int ADDR_W = 64;
   localparam int STATUS_W = 3;

   localparam logic CMD_ADD = 1'b0;
   localparam logic CMD_RESOLVE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_ADDED     = 3'd0,
      STATUS_DUPLICATE = 3'd1,
      STATUS_OVERFLOW  = 3'd2,
      STATUS_FULL      = 3'd3,
      STATUS_RESOLVED  = 3'd4,
      STATUS_NOT_FOUND = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_SEARCH,
      ST_SWEEP,
      ST_EVAL,
      ST_INSERT,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic capture;
      logic scan_clear;
      logic scan_en;
      logic insert;
      logic resolve;
   } cell_ctl_type;

endpackage
`default_nettype wire

// ----- rtl/rtt_cell.sv -----
// One table cell: a stored range, its compare flags and one stage of the scan line.
`timescale 1ns / 1ps
`default_nettype none
module rtt_cell #(
   parameter int INDEX = 0,
   parameter int IDX_W = 6
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire rtt_pkg::cell_ctl_type          ctl,
   input  wire logic [rtt_pkg::ADDR_W-1:0]     req_addr,
   input  wire logic [rtt_pkg::ADDR_W-1:0]     req_phys,
   input  wire logic [rtt_pkg::ADDR_W-1:0]     req_len,
   input  wire logic [IDX_W-1:0]               hit_idx,
   input  wire logic                           prev_valid,
   input  wire logic                           prev_greater,
   input  wire logic [rtt_pkg::ADDR_W-1:0]     prev_start,
   input  wire logic [rtt_pkg::ADDR_W-1:0]     prev_len,
   input  wire logic [rtt_pkg::ADDR_W-1:0]     prev_phys,
   input  wire logic                           prev_scan_hit,
   input  wire logic [rtt_pkg::ADDR_W-1:0]     prev_scan_data,
   output logic                                valid,
   output logic                                greater,
   output logic [rtt_pkg::ADDR_W-1:0]          start,
   output logic [rtt_pkg::ADDR_W-1:0]          len,
   output logic [rtt_pkg::ADDR_W-1:0]          phys,
   output logic                                lt_flag,
   output logic                                beyond_flag,
   output logic                                scan_hit,
   output logic [rtt_pkg::ADDR_W-1:0]          scan_data
);

   logic                          valid_ff, valid_in;
   logic [rtt_pkg::ADDR_W-1:0]    start_ff, start_in;
   logic [rtt_pkg::ADDR_W-1:0]    len_ff, len_in;
   logic [rtt_pkg::ADDR_W-1:0]    phys_ff, phys_in;
   logic                          lt_ff, lt_in;
   logic                          beyond_ff, beyond_in;
   logic                          eq_ff, eq_in;
   logic                          scan_hit_ff, scan_hit_in;
   logic [rtt_pkg::ADDR_W-1:0]    scan_data_ff, scan_data_in;
   logic                          sel;
   logic [rtt_pkg::ADDR_W-1:0]    offset;
   logic [rtt_pkg::ADDR_W-1:0]    translated;

   assign greater = !valid_ff || lt_ff;
   assign offset = req_addr - start_ff;
   assign translated = phys_ff + offset;
   assign sel = ctl.resolve ? (hit_idx == IDX_W'(INDEX)) : (valid_ff && eq_ff);

   always_comb begin
      valid_in = valid_ff;
      start_in = start_ff;
      len_in = len_ff;
      phys_in = phys_ff;
      if (ctl.insert && greater) begin
         valid_in = 1'b1;
         if (prev_greater) begin
            valid_in = prev_valid;
            start_in = prev_start;
            len_in = prev_len;
            phys_in = prev_phys;
         end else begin
            start_in = req_addr;
            len_in = req_len;
            phys_in = req_phys;
         end
      end
   end

   always_comb begin
      lt_in = lt_ff;
      beyond_in = beyond_ff;
      eq_in = eq_ff;
      if (ctl.capture) begin
         lt_in = req_addr < start_ff;
         beyond_in = offset >= len_ff;
         eq_in = req_addr == start_ff;
      end
   end

   always_comb begin
      scan_hit_in = scan_hit_ff;
      scan_data_in = scan_data_ff;
      if (ctl.scan_clear) begin
         scan_hit_in = 1'b0;
         scan_data_in = '0;
      end else if (ctl.scan_en) begin
         scan_hit_in = prev_scan_hit || sel;
         scan_data_in = sel ? translated : prev_scan_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      len_ff <= len_in;
      phys_ff <= phys_in;
      lt_ff <= lt_in;
      beyond_ff <= beyond_in;
      eq_ff <= eq_in;
      scan_hit_ff <= scan_hit_in;
      scan_data_ff <= scan_data_in;
   end

   assign valid = valid_ff;
   assign start = start_ff;
   assign len = len_ff;
   assign phys = phys_ff;
   assign lt_flag = lt_ff;
   assign beyond_flag = beyond_ff;
   assign scan_hit = scan_hit_ff;
   assign scan_data = scan_data_ff;

endmodule
`default_nettype wire

// ----- rtl/rtt_chain.sv -----
// Row of table cells linked to their left neighbors for insertion shifts and the scan line.
`timescale 1ns / 1ps
`default_nettype none
module rtt_chain #(
   parameter int TABLE_DEPTH = rtt_pkg::DEFAULT_TABLE_DEPTH,
   parameter int IDX_W = $clog2(TABLE_DEPTH)
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire rtt_pkg::cell_ctl_type          ctl,
   input  wire logic [rtt_pkg::ADDR_W-1:0]     req_addr,
   input  wire logic [rtt_pkg::ADDR_W-1:0]     req_phys,
   input  wire logic [rtt_pkg::ADDR_W-1:0]     req_len,
   input  wire logic [IDX_W-1:0]               hit_idx,
   output logic [TABLE_DEPTH-1:0]              lt_vec,
   output logic [TABLE_DEPTH-1:0]              beyond_vec,
   output logic                                scan_hit,
   output logic [rtt_pkg::ADDR_W-1:0]          scan_data
);

   logic [TABLE_DEPTH-1:0]        valid_vec;
   logic [TABLE_DEPTH-1:0]        greater_vec;
   logic [TABLE_DEPTH-1:0]        hit_vec;
   logic [rtt_pkg::ADDR_W-1:0]    start_arr [TABLE_DEPTH];
   logic [rtt_pkg::ADDR_W-1:0]    len_arr [TABLE_DEPTH];
   logic [rtt_pkg::ADDR_W-1:0]    phys_arr [TABLE_DEPTH];
   logic [rtt_pkg::ADDR_W-1:0]    data_arr [TABLE_DEPTH];

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         rtt_cell #(
            .INDEX (i),
            .IDX_W (IDX_W)
         ) u_cell (
            .clock          (clock),
            .reset          (reset),
            .ctl            (ctl),
            .req_addr       (req_addr),
            .req_phys       (req_phys),
            .req_len        (req_len),
            .hit_idx        (hit_idx),
            .prev_valid     (1'b1),
            .prev_greater   (1'b0),
            .prev_start     ('0),
            .prev_len       ('0),
            .prev_phys      ('0),
            .prev_scan_hit  (1'b0),
            .prev_scan_data ('0),
            .valid          (valid_vec[i]),
            .greater        (greater_vec[i]),
            .start          (start_arr[i]),
            .len            (len_arr[i]),
            .phys           (phys_arr[i]),
            .lt_flag        (lt_vec[i]),
            .beyond_flag    (beyond_vec[i]),
            .scan_hit       (hit_vec[i]),
            .scan_data      (data_arr[i])
         );
      end else begin : g_body
         rtt_cell #(
            .INDEX (i),
            .IDX_W (IDX_W)
         ) u_cell (
            .clock          (clock),
            .reset          (reset),
            .ctl            (ctl),
            .req_addr       (req_addr),
            .req_phys       (req_phys),
            .req_len        (req_len),
            .hit_idx        (hit_idx),
            .prev_valid     (valid_vec[i-1]),
            .prev_greater   (greater_vec[i-1]),
            .prev_start     (start_arr[i-1]),
            .prev_len       (len_arr[i-1]),
            .prev_phys      (phys_arr[i-1]),
            .prev_scan_hit  (hit_vec[i-1]),
            .prev_scan_data (data_arr[i-1]),
            .valid          (valid_vec[i]),
            .greater        (greater_vec[i]),
            .start          (start_arr[i]),
            .len            (len_arr[i]),
            .phys           (phys_arr[i]),
            .lt_flag        (lt_vec[i]),
            .beyond_flag    (beyond_vec[i]),
            .scan_hit       (hit_vec[i]),
            .scan_data      (data_arr[i])
         );
      end
   end

   assign scan_hit = hit_vec[TABLE_DEPTH-1];
   assign scan_data = data_arr[TABLE_DEPTH-1];

endmodule
`default_nettype wire

// ----- rtl/range_translation_table_core.sv -----
// Top level of the range translation table: request control, search sequencer and result register.
//
// The table holds up to TABLE_DEPTH address ranges sorted by logical start, one range per cell
// in a chain of cells. Every transaction takes its inputs from req_tdata and req_tuser and
// returns exactly one result transaction. An add sends duplicate detection along the scan line
// through every cell, one cell per cycle, then inserts the range unless it is a duplicate or the
// table is full; an add whose range would run past the top of the address space skips the sweep.
// A resolve runs a binary search of at most log2(TABLE_DEPTH) + 1 probes, and the hit cell's
// translated address then also travels the scan line; a miss returns without the sweep, and
// an empty table returns without a search. One transaction is in the table at a time; a
// finished result waits in the output register while the next transaction is accepted.
`timescale 1ns / 1ps
`default_nettype none
module range_translation_table_core #(
   parameter int TABLE_DEPTH = rtt_pkg::DEFAULT_TABLE_DEPTH
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // [63:0] logical_addr, [127:64] physical_start, [191:128] range_length
   input  wire logic [191:0]  req_tdata,
   // [0] cmd
   input  wire logic [0:0]    req_tuser,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // [63:0] physical_addr
   output logic [63:0]        rsp_tdata,
   // [2:0] status
   output logic [2:0]         rsp_tuser
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int AW = rtt_pkg::ADDR_W;

   rtt_pkg::state_type            state_ff, state_in;
   rtt_pkg::cell_ctl_type         ctl;
   logic                          cmd_ff, cmd_in;
   logic [AW-1:0]                 addr_ff, addr_in;
   logic [AW-1:0]                 phys_ff, phys_in;
   logic [AW-1:0]                 len_ff, len_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [CNT_W-1:0]              lo_ff, lo_in;
   logic [CNT_W-1:0]              hip1_ff, hip1_in;
   logic [IDX_W-1:0]              hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0]              sweep_cnt_ff, sweep_cnt_in;
   rtt_pkg::status_type           res_status_ff, res_status_in;
   logic [AW-1:0]                 res_addr_ff, res_addr_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   rtt_pkg::status_type           rsp_status_ff, rsp_status_in;
   logic [AW-1:0]                 rsp_addr_ff, rsp_addr_in;

   logic [TABLE_DEPTH-1:0]        lt_vec;
   logic [TABLE_DEPTH-1:0]        beyond_vec;
   logic                          scan_hit;
   logic [AW-1:0]                 scan_data;
   logic [CNT_W:0]                mid_sum;
   logic [IDX_W-1:0]              mid;
   logic                          overflow;
   logic                          search_live;
   logic                          sweep_last;
   logic                          table_full;
   logic                          rsp_free;
   logic                          req_fire;

   assign req_fire = req_tvalid && req_tready;
   assign overflow = (~addr_ff) < len_ff;
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hip1_ff} - (CNT_W + 1)'(1);
   assign mid = mid_sum[IDX_W:1];
   assign search_live = lo_ff < hip1_ff;
   assign sweep_last = sweep_cnt_ff == IDX_W'(TABLE_DEPTH - 1);
   assign table_full = count_ff == CNT_W'(TABLE_DEPTH);
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   rtt_chain #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_W       (IDX_W)
   ) u_chain (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .req_addr   (addr_ff),
      .req_phys   (phys_ff),
      .req_len    (len_ff),
      .hit_idx    (hit_idx_ff),
      .lt_vec     (lt_vec),
      .beyond_vec (beyond_vec),
      .scan_hit   (scan_hit),
      .scan_data  (scan_data)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rtt_pkg::ST_IDLE: begin
            if (req_fire) state_in = rtt_pkg::ST_COMPARE;
         end
         rtt_pkg::ST_COMPARE: begin
            if (cmd_ff == rtt_pkg::CMD_ADD) begin
               state_in = overflow ? rtt_pkg::ST_RESULT : rtt_pkg::ST_SWEEP;
            end else begin
               state_in = (count_ff == '0) ? rtt_pkg::ST_RESULT : rtt_pkg::ST_SEARCH;
            end
         end
         rtt_pkg::ST_SEARCH: begin
            if (!search_live) begin
               state_in = rtt_pkg::ST_RESULT;
            end else if (!lt_vec[mid] && !beyond_vec[mid]) begin
               state_in = rtt_pkg::ST_SWEEP;
            end
         end
         rtt_pkg::ST_SWEEP: begin
            if (sweep_last) state_in = rtt_pkg::ST_EVAL;
         end
         rtt_pkg::ST_EVAL: begin
            if (cmd_ff == rtt_pkg::CMD_ADD && !scan_hit && !table_full) begin
               state_in = rtt_pkg::ST_INSERT;
            end else begin
               state_in = rtt_pkg::ST_RESULT;
            end
         end
         rtt_pkg::ST_INSERT: begin
            state_in = rtt_pkg::ST_RESULT;
         end
         rtt_pkg::ST_RESULT: begin
            if (rsp_free) state_in = rtt_pkg::ST_IDLE;
         end
         default: state_in = rtt_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      ctl = '0;
      ctl.resolve = cmd_ff == rtt_pkg::CMD_RESOLVE;
      unique case (state_ff)
         rtt_pkg::ST_IDLE: req_tready = 1'b1;
         rtt_pkg::ST_COMPARE: begin
            ctl.capture = 1'b1;
            ctl.scan_clear = 1'b1;
         end
         rtt_pkg::ST_SWEEP: ctl.scan_en = 1'b1;
         rtt_pkg::ST_INSERT: ctl.insert = 1'b1;
         rtt_pkg::ST_SEARCH, rtt_pkg::ST_EVAL, rtt_pkg::ST_RESULT: ;
         default: ;
      endcase
   end

   always_comb begin
      cmd_in = cmd_ff;
      addr_in = addr_ff;
      phys_in = phys_ff;
      len_in = len_ff;
      count_in = count_ff;
      lo_in = lo_ff;
      hip1_in = hip1_ff;
      hit_idx_in = hit_idx_ff;
      sweep_cnt_in = sweep_cnt_ff;
      res_status_in = res_status_ff;
      res_addr_in = res_addr_ff;
      case (state_ff)
         rtt_pkg::ST_IDLE: begin
            if (req_fire) begin
               cmd_in = req_tuser[0];
               addr_in = req_tdata[63:0];
               phys_in = req_tdata[127:64];
               len_in = req_tdata[191:128];
            end
         end
         rtt_pkg::ST_COMPARE: begin
            lo_in = '0;
            hip1_in = count_ff;
            sweep_cnt_in = '0;
            res_addr_in = '1;
            if (cmd_ff == rtt_pkg::CMD_ADD) begin
               res_status_in = rtt_pkg::STATUS_OVERFLOW;
            end else begin
               res_status_in = rtt_pkg::STATUS_NOT_FOUND;
            end
         end
         rtt_pkg::ST_SEARCH: begin
            if (search_live) begin
               if (lt_vec[mid]) begin
                  hip1_in = CNT_W'(mid);
               end else if (beyond_vec[mid]) begin
                  lo_in = CNT_W'(mid) + CNT_W'(1);
               end else begin
                  hit_idx_in = mid;
               end
            end
         end
         rtt_pkg::ST_SWEEP: begin
            sweep_cnt_in = sweep_cnt_ff + IDX_W'(1);
         end
         rtt_pkg::ST_EVAL: begin
            if (cmd_ff == rtt_pkg::CMD_RESOLVE) begin
               res_status_in = rtt_pkg::STATUS_RESOLVED;
               res_addr_in = scan_data;
            end else if (scan_hit) begin
               res_status_in = rtt_pkg::STATUS_DUPLICATE;
            end else if (table_full) begin
               res_status_in = rtt_pkg::STATUS_FULL;
            end else begin
               res_status_in = rtt_pkg::STATUS_ADDED;
            end
         end
         rtt_pkg::ST_INSERT: begin
            count_in = count_ff + CNT_W'(1);
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in = rsp_addr_ff;
      if (rsp_tready) rsp_valid_in = 1'b0;
      if (state_ff == rtt_pkg::ST_RESULT && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_addr_in = res_addr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rtt_pkg::ST_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      addr_ff <= addr_in;
      phys_ff <= phys_in;
      len_ff <= len_in;
      lo_ff <= lo_in;
      hip1_ff <= hip1_in;
      hit_idx_ff <= hit_idx_in;
      sweep_cnt_ff <= sweep_cnt_in;
      res_status_ff <= res_status_in;
      res_addr_ff <= res_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff <= rsp_addr_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_addr_ff;
   assign rsp_tuser = rsp_status_ff;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count exceeds the table depth");

   a_insert_counts: assert property (@(posedge clock) disable iff (reset)
      state_ff == rtt_pkg::ST_INSERT |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insertion did not advance the entry count");

   a_no_insert_when_full: assert property (@(posedge clock) disable iff (reset)
      state_ff == rtt_pkg::ST_INSERT |-> !table_full)
      else $error("insertion into a full table");

   a_search_bounds: assert property (@(posedge clock) disable iff (reset)
      state_ff == rtt_pkg::ST_SEARCH |-> hip1_ff <= count_ff && lo_ff <= count_ff)
      else $error("binary search bounds left the table");

   a_miss_all_ones: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != rtt_pkg::STATUS_RESOLVED |-> rsp_tdata == '1)
      else $error("address field not all ones on a non-resolved transaction");

endmodule
`default_nettype wire
